// ===== rtl/rpp_pkg.sv =====
// Shared types, codes and the attribute dictionary of the RADIUS packet parser.
`default_nettype none

package rpp_pkg;

	localparam int unsigned HDR_BYTES      = 20;
	localparam int unsigned ATTR_MIN_BYTES = 2;
	localparam int unsigned APB_ADDR_W     = 3;
	localparam int unsigned CFG_W          = 13;

	// result kinds
	localparam logic [2:0] KIND_HEADER = 3'd0;
	localparam logic [2:0] KIND_AUTH   = 3'd1;
	localparam logic [2:0] KIND_ATTR   = 3'd2;
	localparam logic [2:0] KIND_VALUE  = 3'd3;
	localparam logic [2:0] KIND_DATA   = 3'd4;
	localparam logic [2:0] KIND_STATUS = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT_BUF = 3'd1;
	localparam logic [2:0] ST_LEN_BUF   = 3'd2;
	localparam logic [2:0] ST_LEN_RANGE = 3'd3;
	localparam logic [2:0] ST_OVERRUN   = 3'd4;

	// data classes
	localparam logic [2:0] CL_TEXT    = 3'd0;
	localparam logic [2:0] CL_STRING  = 3'd1;
	localparam logic [2:0] CL_ADDRESS = 3'd2;
	localparam logic [2:0] CL_INTEGER = 3'd3;
	localparam logic [2:0] CL_TIME    = 3'd4;
	localparam logic [2:0] CL_UNKNOWN = 3'd5;

	// register word indexes
	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  code_or_type;
		logic [7:0]  identifier;
		logic [12:0] length_value;
		logic [2:0]  data_class;
		logic [31:0] value;
		logic [7:0]  payload_byte;
		logic        bad_length;
		logic [2:0]  status;
		logic        last;
	} result_t;

	// one queue entry: a result, optionally followed by a closing ok status
	typedef struct packed {
		result_t res;
		logic    close_ok;
	} cmd_t;

	function automatic logic [2:0] lookup_class(input logic [7:0] atype);
		logic [2:0] cls;
		unique case (atype) inside
			8'd1, 8'd2, 8'd11, [8'd18:8'd20], 8'd22, [8'd30:8'd32], 8'd34, 8'd35,
			8'd39, 8'd44, 8'd50, 8'd68, 8'd70, 8'd71, 8'd74, 8'd77, 8'd78, 8'd84,
			8'd87, 8'd88, 8'd99, 8'd100, 8'd206:
				cls = CL_TEXT;
			8'd3, [8'd24:8'd26], 8'd33, 8'd36, 8'd60, 8'd79, 8'd80,
			[8'd95:8'd98], 8'd207:
				cls = CL_STRING;
			8'd4, 8'd8, 8'd9, 8'd14, 8'd23:
				cls = CL_ADDRESS;
			[8'd5:8'd7], 8'd10, 8'd12, 8'd13, 8'd15, 8'd16, [8'd27:8'd29],
			8'd37, 8'd38, [8'd40:8'd43], [8'd45:8'd49], [8'd51:8'd53],
			[8'd61:8'd63], 8'd72, 8'd73, 8'd75, 8'd76, 8'd85, 8'd101:
				cls = CL_INTEGER;
			8'd55:
				cls = CL_TIME;
			default:
				cls = CL_UNKNOWN;
		endcase
		return cls;
	endfunction

	function automatic logic is_numeric(input logic [2:0] cls);
		return (cls == CL_INTEGER) || (cls == CL_ADDRESS) || (cls == CL_TIME);
	endfunction

	function automatic result_t status_result(input logic [2:0] st);
		result_t r;
		r        = '0;
		r.kind   = KIND_STATUS;
		r.status = st;
		r.last   = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rpp_in_if.sv =====
// Input byte channel of the RADIUS packet parser.
`default_nettype none

interface rpp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic [15:0] buffer_len;

	modport source(output valid, data_byte, first_byte, buffer_len, input ready);
	modport sink(input valid, data_byte, first_byte, buffer_len, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpp_out_if.sv =====
// Result channel of the RADIUS packet parser.
`default_nettype none

interface rpp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  code_or_type;
	logic [7:0]  identifier;
	logic [12:0] length_value;
	logic [2:0]  data_class;
	logic [31:0] value;
	logic [7:0]  payload_byte;
	logic        bad_length;
	logic [2:0]  status;
	logic        last;

	modport source(output valid, kind, code_or_type, identifier, length_value, data_class,
		value, payload_byte, bad_length, status, last, input ready);
	modport sink(input valid, kind, code_or_type, identifier, length_value, data_class,
		value, payload_byte, bad_length, status, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/radius_packet_parser.sv =====
// RADIUS packet parser top level: config registers, front end, queue, back end.
//
//  channel  dir  handshake            carries
//  in_ch    in   valid/ready          data_byte, first_byte, buffer_len
//  out_ch   out  valid/ready          one parsed result (header .. status)
//  apb      in   psel/penable/pwrite  min_packet_len @0x0, max_packet_len @0x4
//
//  One input byte is taken per cycle while the command queue has room.
//  An accepted byte's result is written into the queue, then into the output register.
//  A byte that yields a result plus a closing status makes the back end send both
//  from one queue entry; the queue (FIFO_DEPTH entries) absorbs this and output stalls.
//  Reset returns the parser to idle and the registers to 20 and 4096.
`default_nettype none

module radius_packet_parser #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	rpp_in_if.sink                               in_ch,
	rpp_out_if.source                            out_ch,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rpp_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import rpp_pkg::*;

	logic [CFG_W-1:0] min_len_q;
	logic [CFG_W-1:0] max_len_q;
	logic             cfg_wr;
	logic             q_ready;
	logic             q_push;
	cmd_t             q_wdata;
	logic             q_pop;
	cmd_t             q_rdata;
	logic             q_valid;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {{(32 - CFG_W){1'b0}},
		(paddr[2] == REG_MAX_LEN) ? max_len_q : min_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= CFG_W'(20);
			max_len_q <= CFG_W'(4096);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MIN_LEN) begin
				min_len_q <= pwdata[CFG_W-1:0];
			end else begin
				max_len_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	rpp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.min_len (min_len_q),
		.max_len (max_len_q),
		.q_ready (q_ready),
		.push    (q_push),
		.cmd     (q_wdata)
	);

	rpp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.ready     (q_ready),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.not_empty (q_valid)
	);

	rpp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_rdata),
		.pop     (q_pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// ===== rtl/rpp_front.sv =====
// Front end: byte intake and packet/attribute parse state machine.
`default_nettype none

module rpp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rpp_in_if.sink                             in_ch,
	input  wire logic [rpp_pkg::CFG_W-1:0]     min_len,
	input  wire logic [rpp_pkg::CFG_W-1:0]     max_len,
	input  wire logic                          q_ready,
	output logic                               push,
	output rpp_pkg::cmd_t                      cmd
);
	import rpp_pkg::*;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_HEAD  = 6'b000010,
		PH_AUTH  = 6'b000100,
		PH_ATYPE = 6'b001000,
		PH_ALEN  = 6'b010000,
		PH_ADATA = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [12:0] pos_q, pos_d;
	logic [12:0] plen_q, plen_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] blen_q, blen_d;
	logic [7:0]  code_q, code_d;
	logic [7:0]  ident_q, ident_d;
	logic [7:0]  atype_q, atype_d;
	logic [7:0]  arem_q, arem_d;
	logic [2:0]  acls_q, acls_d;
	logic [31:0] acc_q, acc_d;
	logic        abad_q, abad_d;

	logic        take;
	logic [12:0] pos_inc;
	logic [12:0] emin;
	logic [15:0] len16;
	logic [7:0]  vlen;
	logic [2:0]  cls;
	logic        bnd_close;
	logic        emit;
	logic        close;
	result_t     res;

	assign in_ch.ready = q_ready;
	assign take        = in_ch.valid && q_ready;
	assign pos_inc     = pos_q + 13'd1;
	assign emin        = (min_len < CFG_W'(HDR_BYTES)) ? CFG_W'(HDR_BYTES) : min_len;
	assign len16       = {len_hi_q, in_ch.data_byte};
	assign vlen        = in_ch.data_byte - 8'(ATTR_MIN_BYTES);
	assign cls         = lookup_class(atype_q);
	// fewer than two bytes left where the next attribute would start
	assign bnd_close   = ({1'b0, pos_inc} + 14'(ATTR_MIN_BYTES)) > {1'b0, plen_q};

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		plen_d   = plen_q;
		len_hi_d = len_hi_q;
		blen_d   = blen_q;
		code_d   = code_q;
		ident_d  = ident_q;
		atype_d  = atype_q;
		arem_d   = arem_q;
		acls_d   = acls_q;
		acc_d    = acc_q;
		abad_d   = abad_q;
		emit     = 1'b0;
		close    = 1'b0;
		res      = '0;
		if (take) begin
			if (in_ch.first_byte) begin
				blen_d   = in_ch.buffer_len;
				plen_d   = '0;
				len_hi_d = '0;
				atype_d  = '0;
				arem_d   = '0;
				acls_d   = '0;
				acc_d    = '0;
				abad_d   = 1'b0;
				ident_d  = '0;
				if (in_ch.buffer_len < {3'b000, emin}) begin
					pos_d   = '0;
					emit    = 1'b1;
					res     = status_result(ST_SHORT_BUF);
					phase_d = PH_IDLE;
				end else begin
					code_d  = in_ch.data_byte;
					pos_d   = 13'd1;
					phase_d = PH_HEAD;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_HEAD: begin
						pos_d = pos_inc;
						if (pos_q == 13'd1) begin
							ident_d = in_ch.data_byte;
						end else if (pos_q == 13'd2) begin
							len_hi_d = in_ch.data_byte;
						end else if (len16 > blen_q) begin
							emit    = 1'b1;
							res     = status_result(ST_LEN_BUF);
							phase_d = PH_IDLE;
						end else if (len16 < {3'b000, emin} || len16 > {3'b000, max_len}) begin
							emit    = 1'b1;
							res     = status_result(ST_LEN_RANGE);
							phase_d = PH_IDLE;
						end else begin
							plen_d           = len16[12:0];
							emit             = 1'b1;
							res.kind         = KIND_HEADER;
							res.code_or_type = code_q;
							res.identifier   = ident_q;
							res.length_value = len16[12:0];
							phase_d          = PH_AUTH;
						end
					end
					PH_AUTH: begin
						pos_d            = pos_inc;
						emit             = 1'b1;
						res.kind         = KIND_AUTH;
						res.payload_byte = in_ch.data_byte;
						if (pos_inc >= 13'(HDR_BYTES)) begin
							if (bnd_close) begin
								close   = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_ATYPE;
							end
						end
					end
					PH_ATYPE: begin
						atype_d = in_ch.data_byte;
						pos_d   = pos_inc;
						phase_d = PH_ALEN;
					end
					PH_ALEN: begin
						pos_d = pos_inc;
						if (in_ch.data_byte < 8'(ATTR_MIN_BYTES) ||
							({1'b0, pos_inc} + {6'b0, vlen}) > {1'b0, plen_q}) begin
							emit    = 1'b1;
							res     = status_result(ST_OVERRUN);
							phase_d = PH_IDLE;
						end else begin
							acls_d           = cls;
							abad_d           = is_numeric(cls) && (vlen != 8'd4);
							arem_d           = vlen;
							acc_d            = '0;
							emit             = 1'b1;
							res.kind         = KIND_ATTR;
							res.code_or_type = atype_q;
							res.length_value = {5'b0, vlen};
							res.data_class   = cls;
							res.bad_length   = is_numeric(cls) && (vlen != 8'd4);
							if (vlen == 8'd0) begin
								if (bnd_close) begin
									close   = 1'b1;
									phase_d = PH_IDLE;
								end else begin
									phase_d = PH_ATYPE;
								end
							end else begin
								phase_d = PH_ADATA;
							end
						end
					end
					PH_ADATA: begin
						pos_d = pos_inc;
						if (arem_q != 8'd0) begin
							arem_d = arem_q - 8'd1;
						end
						if (is_numeric(acls_q)) begin
							acc_d = {acc_q[23:0], in_ch.data_byte};
							if (arem_d == 8'd0 && !abad_q) begin
								emit             = 1'b1;
								res.kind         = KIND_VALUE;
								res.code_or_type = atype_q;
								res.length_value = 13'd4;
								res.data_class   = acls_q;
								res.value        = {acc_q[23:0], in_ch.data_byte};
							end
						end else begin
							emit             = 1'b1;
							res.kind         = KIND_DATA;
							res.code_or_type = atype_q;
							res.data_class   = acls_q;
							res.payload_byte = in_ch.data_byte;
						end
						if (arem_d == 8'd0) begin
							if (bnd_close) begin
								close   = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_ATYPE;
							end
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// a close with nothing before it travels as a plain status entry
	always_comb begin
		push = emit || close;
		if (emit) begin
			cmd.res      = res;
			cmd.close_ok = close;
		end else begin
			cmd.res      = status_result(ST_OK);
			cmd.close_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			plen_q   <= '0;
			len_hi_q <= '0;
			blen_q   <= '0;
			code_q   <= '0;
			ident_q  <= '0;
			atype_q  <= '0;
			arem_q   <= '0;
			acls_q   <= '0;
			acc_q    <= '0;
			abad_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			plen_q   <= plen_d;
			len_hi_q <= len_hi_d;
			blen_q   <= blen_d;
			code_q   <= code_d;
			ident_q  <= ident_d;
			atype_q  <= atype_d;
			arem_q   <= arem_d;
			acls_q   <= acls_d;
			acc_q    <= acc_d;
			abad_q   <= abad_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rpp_fifo.sv =====
// Short command queue between the parse front end and the result back end.
`default_nettype none

module rpp_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  rpp_pkg::cmd_t      wdata,
	output logic               ready,
	input  wire logic          pop,
	output rpp_pkg::cmd_t      rdata,
	output logic               not_empty
);
	import rpp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready     = count_q != CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign rdata     = entry_q[rptr_q];
	assign do_push   = push && ready;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rpp_back.sv =====
// Back end: expands queued commands into results and holds the output register.
`default_nettype none

module rpp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  rpp_pkg::cmd_t      q_cmd,
	output logic               pop,
	rpp_out_if.source          out_ch
);
	import rpp_pkg::*;

	result_t res_q, res_d;
	logic    valid_q, valid_d;
	logic    pend_q, pend_d;
	logic    load;

	assign load = !valid_q || out_ch.ready;

	always_comb begin
		res_d   = res_q;
		valid_d = valid_q;
		pend_d  = pend_q;
		pop     = 1'b0;
		if (load) begin
			if (pend_q) begin
				res_d   = status_result(ST_OK);
				valid_d = 1'b1;
				pend_d  = 1'b0;
			end else if (q_valid) begin
				pop     = 1'b1;
				res_d   = q_cmd.res;
				valid_d = 1'b1;
				pend_d  = q_cmd.close_ok;
			end else begin
				valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			valid_q <= valid_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.kind         = res_q.kind;
	assign out_ch.code_or_type = res_q.code_or_type;
	assign out_ch.identifier   = res_q.identifier;
	assign out_ch.length_value = res_q.length_value;
	assign out_ch.data_class   = res_q.data_class;
	assign out_ch.value        = res_q.value;
	assign out_ch.payload_byte = res_q.payload_byte;
	assign out_ch.bad_length   = res_q.bad_length;
	assign out_ch.status       = res_q.status;
	assign out_ch.last         = res_q.last;

endmodule

`default_nettype wire

// ===== rtl/rpp_checker.sv =====
// Port-level assertions for the RADIUS packet parser, bound to the top level.
`default_nettype none

module rpp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [12:0] length_value,
	input wire logic [31:0] value,
	input wire logic [2:0]  status,
	input wire logic        last
);
	import rpp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status))
		else $error("result changed while stalled");

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (kind == KIND_STATUS)))
		else $error("last does not match status result");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_STATUS |-> status == ST_OK)
		else $error("nonzero status on a non-status result");

	a_value_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_VALUE |-> length_value == 13'd4)
		else $error("integer value result without length four");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_AUTH || kind == KIND_DATA) |-> value == 32'd0)
		else $error("byte result carries a value");

endmodule

bind radius_packet_parser rpp_checker u_rpp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.kind         (out_ch.kind),
	.length_value (out_ch.length_value),
	.value        (out_ch.value),
	.status       (out_ch.status),
	.last         (out_ch.last)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the RADIUS packet parser: directed buffers, limits and random traffic.
`timescale 1ns / 100ps

module testbench;
	import rpp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_HEAD, PH_AUTH, PH_ATYPE, PH_ALEN, PH_ADATA
	} rx_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	wire [31:0] prdata;
	wire pready;

	rpp_in_if in_ch();
	rpp_out_if out_ch();

	radius_packet_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// parser state mirror
	logic [12:0] min_len = 13'd20;
	logic [12:0] max_len = 13'h1000;
	rx_phase_t rx_phase = PH_IDLE;
	int unsigned rx_pos, pkt_len, buf_len, attr_left;
	logic [7:0] rx_atype, pkt_code, pkt_ident;
	logic [2:0] attr_cls;
	logic [31:0] attr_acc;
	logic attr_bad;

	result_t predicted_results[$];
	int unsigned fault_count, bytes_taken, bytes_parsed;
	int unsigned results_seen, closures_seen, values_seen, data_seen;
	int unsigned gap_pct, stall_pct;

	function automatic logic [2:0] attr_class(input logic [7:0] t);
		case (t)
			1, 2, 11, 18, 19, 20, 22, 30, 31, 32, 34, 35, 39, 44, 50, 68, 70, 71, 74, 77, 78,
			84, 87, 88, 99, 100, 206:
				return CL_TEXT;
			3, 24, 25, 26, 33, 36, 60, 79, 80, 95, 96, 97, 98, 207:
				return CL_STRING;
			4, 8, 9, 14, 23:
				return CL_ADDRESS;
			5, 6, 7, 10, 12, 13, 15, 16, 27, 28, 29, 37, 38, 40, 41, 42, 43, 45, 46, 47, 48,
			49, 51, 52, 53, 61, 62, 63, 72, 73, 75, 76, 85, 101:
				return CL_INTEGER;
			55:
				return CL_TIME;
			default:
				return CL_UNKNOWN;
		endcase
	endfunction

	function automatic void add_expect(input logic [2:0] kind, input logic [7:0] ct,
			input logic [7:0] id, input logic [12:0] len, input logic [2:0] cls,
			input logic [31:0] val, input logic [7:0] pay, input logic bad);
		result_t r;
		r = '0;
		r.kind = kind;
		r.code_or_type = ct;
		r.identifier = id;
		r.length_value = len;
		r.data_class = cls;
		r.value = val;
		r.payload_byte = pay;
		r.bad_length = bad;
		predicted_results.push_back(r);
	endfunction

	function automatic void close_packet(input logic [2:0] st);
		result_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = st;
		r.last = 1'b1;
		predicted_results.push_back(r);
		rx_phase = PH_IDLE;
	endfunction

	function automatic void attr_boundary();
		if (rx_pos + ATTR_MIN_BYTES > pkt_len)
			close_packet(ST_OK);
		else
			rx_phase = PH_ATYPE;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic f, input logic [15:0] bl);
		int unsigned emin, len, vlen;
		logic numeric;
		emin = (32'(min_len) < HDR_BYTES) ? HDR_BYTES : 32'(min_len);
		if (f) begin
			buf_len = 32'(bl);
			pkt_len = 0;
			rx_atype = '0;
			attr_left = 0;
			attr_cls = '0;
			attr_acc = '0;
			attr_bad = 1'b0;
			pkt_ident = '0;
			if (32'(bl) < emin) begin
				rx_pos = 0;
				close_packet(ST_SHORT_BUF);
			end else begin
				pkt_code = b;
				rx_pos = 1;
				rx_phase = PH_HEAD;
			end
			return;
		end
		case (rx_phase)
			PH_HEAD: begin
				if (rx_pos == 1) begin
					pkt_ident = b;
				end else if (rx_pos == 2) begin
					pkt_len = 32'(b);
				end else begin
					len = (pkt_len << 8) | 32'(b);
					if (len > buf_len) begin
						close_packet(ST_LEN_BUF);
						return;
					end
					if (len < emin || len > 32'(max_len)) begin
						close_packet(ST_LEN_RANGE);
						return;
					end
					pkt_len = len & 32'h1fff;
					add_expect(KIND_HEADER, pkt_code, pkt_ident, 13'(pkt_len), CL_TEXT, '0, '0,
						1'b0);
					rx_phase = PH_AUTH;
				end
				rx_pos++;
			end
			PH_AUTH: begin
				add_expect(KIND_AUTH, '0, '0, '0, CL_TEXT, '0, b, 1'b0);
				rx_pos++;
				if (rx_pos >= HDR_BYTES)
					attr_boundary();
			end
			PH_ATYPE: begin
				rx_atype = b;
				rx_pos++;
				rx_phase = PH_ALEN;
			end
			PH_ALEN: begin
				rx_pos++;
				if (32'(b) < ATTR_MIN_BYTES) begin
					close_packet(ST_OVERRUN);
					return;
				end
				vlen = 32'(b) - ATTR_MIN_BYTES;
				if (rx_pos + vlen > pkt_len) begin
					close_packet(ST_OVERRUN);
					return;
				end
				attr_cls = attr_class(rx_atype);
				numeric = attr_cls == CL_INTEGER || attr_cls == CL_ADDRESS || attr_cls == CL_TIME;
				attr_bad = numeric && vlen != 4;
				attr_left = vlen;
				attr_acc = '0;
				add_expect(KIND_ATTR, rx_atype, '0, 13'(vlen), attr_cls, '0, '0, attr_bad);
				if (vlen == 0)
					attr_boundary();
				else
					rx_phase = PH_ADATA;
			end
			PH_ADATA: begin
				rx_pos++;
				if (attr_left > 0)
					attr_left--;
				if (attr_cls == CL_INTEGER || attr_cls == CL_ADDRESS || attr_cls == CL_TIME) begin
					attr_acc = {attr_acc[23:0], b};
					if (attr_left == 0 && !attr_bad)
						add_expect(KIND_VALUE, rx_atype, '0, 13'd4, attr_cls, attr_acc, '0, 1'b0);
				end else begin
					add_expect(KIND_DATA, rx_atype, '0, '0, attr_cls, '0, b, 1'b0);
				end
				if (attr_left == 0)
					attr_boundary();
			end
			default: ;
		endcase
	endfunction

	// buffer construction
	function automatic void begin_packet(ref logic [7:0] q[$], input logic [7:0] code,
			input logic [7:0] ident);
		q.delete();
		q.push_back(code);
		q.push_back(ident);
		q.push_back(8'd0);
		q.push_back(8'd0);
		repeat (16) q.push_back(8'($urandom));
	endfunction

	function automatic void add_attr(ref logic [7:0] q[$], input logic [7:0] t,
			input int unsigned vlen);
		q.push_back(t);
		q.push_back(8'(vlen + 2));
		repeat (vlen) q.push_back(8'($urandom));
	endfunction

	function automatic void seal_length(ref logic [7:0] q[$]);
		q[2] = 8'(q.size() >> 8);
		q[3] = 8'(q.size());
	endfunction

	// well-formed packet of exactly total bytes
	function automatic void build_packet(ref logic [7:0] q[$], input int unsigned total);
		int unsigned room, vlen;
		logic [7:0] t;
		begin_packet(q, 8'($urandom), 8'($urandom));
		while (q.size() < total) begin
			room = total - q.size();
			if (room < 2) begin
				q.push_back(8'($urandom));
				continue;
			end
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					case ($urandom_range(5))
						0: t = 8'd4;
						1: t = 8'd55;
						2: t = 8'd5;
						3: t = 8'd8;
						4: t = 8'd27;
						default: t = 8'd101;
					endcase
					vlen = ($urandom_range(7) == 0) ? $urandom_range(8) : 4;
				end
				4, 5, 6: begin
					case ($urandom_range(4))
						0: t = 8'd1;
						1: t = 8'd26;
						2: t = 8'd3;
						3: t = 8'd79;
						default: t = 8'd207;
					endcase
					vlen = $urandom_range(10);
				end
				7: begin
					case ($urandom_range(4))
						0: t = 8'd0;
						1: t = 8'd17;
						2: t = 8'd102;
						3: t = 8'd205;
						default: t = 8'd255;
					endcase
					vlen = $urandom_range(6);
				end
				default: begin
					t = 8'($urandom);
					vlen = $urandom_range((total > 300) ? 253 : 20);
				end
			endcase
			if (vlen + 2 > room)
				vlen = room - 2;
			add_attr(q, t, vlen);
		end
		seal_length(q);
	endfunction

	// stimulus
	task automatic push_byte(input logic [7:0] b, input logic f, input logic [15:0] bl);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.first_byte <= f;
		in_ch.buffer_len <= bl;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		bytes_taken++;
		if (f || rx_phase != PH_IDLE)
			bytes_parsed++;
		parse_byte(b, f, bl);
	endtask

	task automatic send_buffer(input logic [7:0] q[$], input logic [15:0] blen);
		foreach (q[i])
			push_byte(q[i], i == 0, (i == 0) ? blen : 16'($urandom));
	endtask

	task automatic send_random_buffer();
		logic [7:0] q[$];
		int unsigned lo, hi, cap, total, blen, keep;
		int unsigned mode;
		lo = (32'(min_len) < HDR_BYTES) ? HDR_BYTES : 32'(min_len);
		hi = (32'(max_len) > lo) ? 32'(max_len) : lo;
		cap = ($urandom_range(15) == 0) ? 300 : 60;
		if (hi > lo + cap)
			hi = lo + cap;
		total = $urandom_range(hi, lo);
		build_packet(q, total);
		blen = total;
		keep = total;
		mode = $urandom_range(99);
		if (mode < 70) begin
			repeat ($urandom_range(3)) q.push_back(8'($urandom));
			blen = q.size();
			keep = q.size();
		end else if (mode < 76) begin
			// length field beyond the buffer
			blen = total - 1 - $urandom_range(3);
			keep = 4 + $urandom_range(4);
		end else if (mode < 82) begin
			blen = $urandom_range(lo - 1);
			keep = 1 + $urandom_range(2);
		end else if (mode < 90) begin
			q[$urandom_range(total - 1, 4)] = 8'($urandom);
		end else if (mode < 95) begin
			// abandoned by the next buffer
			keep = $urandom_range(total - 1, 1);
		end else begin
			q[2] = 8'($urandom);
			q[3] = 8'($urandom);
			blen = $urandom_range(16'hffff);
		end
		while (q.size() > keep) void'(q.pop_back());
		send_buffer(q, 16'(blen));
	endtask

	// config port
	task automatic apb_access(input logic idx, input logic wr, input logic [12:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {19'd0, wdata};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_expect(input logic idx, input logic [12:0] want);
		logic [31:0] rd;
		apb_access(idx, 1'b0, '0, rd);
		if (rd !== {19'd0, want}) begin
			fault_count++;
			$display("%0t register %0d read: expected 0x%0h actual 0x%0h", $time, idx, want, rd);
		end
	endtask

	// drain in-flight work before touching the limits
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (predicted_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limits(input logic [12:0] mn, input logic [12:0] mx);
		logic [31:0] unused;
		settle();
		apb_access(REG_MIN_LEN, 1'b1, mn, unused);
		apb_access(REG_MAX_LEN, 1'b1, mx, unused);
		min_len = mn;
		max_len = mx;
		reg_expect(REG_MIN_LEN, mn);
		reg_expect(REG_MAX_LEN, mx);
	endtask

	// result checking
	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			fault_count++;
			$display("%0t %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, seen);
		end
	endfunction

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.kind = out_ch.kind;
			got.code_or_type = out_ch.code_or_type;
			got.identifier = out_ch.identifier;
			got.length_value = out_ch.length_value;
			got.data_class = out_ch.data_class;
			got.value = out_ch.value;
			got.payload_byte = out_ch.payload_byte;
			got.bad_length = out_ch.bad_length;
			got.status = out_ch.status;
			got.last = out_ch.last;
			results_seen++;
			if (got.kind == KIND_STATUS)
				closures_seen++;
			if (got.kind == KIND_VALUE)
				values_seen++;
			if (got.kind == KIND_DATA)
				data_seen++;
			if (predicted_results.size() == 0) begin
				fault_count++;
				$display("%0t unexpected transaction: expected none actual kind %0d",
					$time, got.kind);
			end else begin
				want = predicted_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("code_or_type", 32'(want.code_or_type), 32'(got.code_or_type));
				check_field("identifier", 32'(want.identifier), 32'(got.identifier));
				check_field("length_value", 32'(want.length_value), 32'(got.length_value));
				check_field("data_class", 32'(want.data_class), 32'(got.data_class));
				check_field("value", want.value, got.value);
				check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
				check_field("bad_length", 32'(want.bad_length), 32'(got.bad_length));
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= stall_pct);

	// tests
	task automatic test_register_access();
		reg_expect(REG_MIN_LEN, 13'd20);
		reg_expect(REG_MAX_LEN, 13'h1000);
		set_limits(13'd37, 13'd1500);
		set_limits(13'd20, 13'h1000);
	endtask

	task automatic test_header_checks();
		logic [7:0] q[$];
		// stray bytes before any buffer
		repeat (3) push_byte(8'($urandom), 1'b0, 16'($urandom));
		push_byte(8'h01, 1'b1, 16'd19);
		push_byte(8'h00, 1'b1, 16'd0);
		// length field 31 in a 30-byte buffer
		push_byte(8'h01, 1'b1, 16'd30);
		push_byte(8'h10, 1'b0, 16'($urandom));
		push_byte(8'h00, 1'b0, 16'($urandom));
		push_byte(8'd31, 1'b0, 16'($urandom));
		repeat (2) push_byte(8'($urandom), 1'b0, 16'($urandom));
		// length below minimum, then the largest length field
		push_byte(8'h01, 1'b1, 16'd100);
		push_byte(8'h22, 1'b0, 16'($urandom));
		push_byte(8'h00, 1'b0, 16'($urandom));
		push_byte(8'd19, 1'b0, 16'($urandom));
		push_byte(8'h01, 1'b1, 16'hffff);
		push_byte(8'h33, 1'b0, 16'($urandom));
		push_byte(8'hff, 1'b0, 16'($urandom));
		push_byte(8'hff, 1'b0, 16'($urandom));
		// restart in the authenticator
		begin_packet(q, 8'h01, 8'h07);
		seal_length(q);
		while (q.size() > 9) void'(q.pop_back());
		send_buffer(q, 16'd20);
		// header-only packet, bytes past its length are dropped
		begin_packet(q, 8'hff, 8'hff);
		seal_length(q);
		repeat (4) q.push_back(8'($urandom));
		send_buffer(q, 16'd24);
		// single byte left where an attribute would start
		begin_packet(q, 8'h02, 8'h00);
		q.push_back(8'hab);
		seal_length(q);
		send_buffer(q, 16'd21);
	endtask

	task automatic test_attributes();
		logic [7:0] q[$];
		begin_packet(q, 8'h04, 8'h80);
		add_attr(q, 8'd4, 4);
		add_attr(q, 8'd55, 4);
		q.push_back(8'd5);
		q.push_back(8'd6);
		repeat (4) q.push_back(8'hff);
		q.push_back(8'd6);
		q.push_back(8'd6);
		repeat (4) q.push_back(8'h00);
		add_attr(q, 8'd26, 3);
		add_attr(q, 8'd1, 0);
		add_attr(q, 8'd255, 2);
		add_attr(q, 8'd0, 1);
		add_attr(q, 8'd6, 2);
		add_attr(q, 8'd4, 0);
		add_attr(q, 8'd101, 7);
		add_attr(q, 8'd26, 253);
		seal_length(q);
		send_buffer(q, 16'(q.size()));
		// attribute length of one, then of zero
		begin_packet(q, 8'h01, 8'h01);
		add_attr(q, 8'd1, 3);
		q.push_back(8'd2);
		q.push_back(8'd1);
		seal_length(q);
		send_buffer(q, 16'(q.size()));
		begin_packet(q, 8'h01, 8'h02);
		q.push_back(8'd4);
		q.push_back(8'd0);
		repeat (4) q.push_back(8'($urandom));
		seal_length(q);
		send_buffer(q, 16'(q.size()));
		// value that runs past the packet length
		begin_packet(q, 8'h01, 8'h03);
		add_attr(q, 8'd1, 2);
		q.push_back(8'd3);
		q.push_back(8'd50);
		repeat (4) q.push_back(8'($urandom));
		seal_length(q);
		send_buffer(q, 16'(q.size()));
	endtask

	task automatic test_length_limits();
		logic [7:0] q[$];
		// minimum under the header size still means 20
		set_limits(13'd0, 13'h1000);
		push_byte(8'h01, 1'b1, 16'd19);
		build_packet(q, 20);
		send_buffer(q, 16'd20);
		// minimum and maximum pinned to one length
		set_limits(13'd100, 13'd100);
		push_byte(8'h01, 1'b1, 16'd99);
		build_packet(q, 100);
		send_buffer(q, 16'd100);
		set_limits(13'h1fff, 13'h1fff);
		push_byte(8'h01, 1'b1, 16'd8190);
		push_byte(8'h01, 1'b1, 16'hffff);
		push_byte(8'h55, 1'b0, 16'($urandom));
		push_byte(8'h20, 1'b0, 16'($urandom));
		push_byte(8'h00, 1'b0, 16'($urandom));
		// maximum under minimum rejects everything
		set_limits(13'd100, 13'd50);
		build_packet(q, 120);
		send_buffer(q, 16'd120);
		set_limits(13'd20, 13'd20);
		build_packet(q, 21);
		send_buffer(q, 16'd21);
		build_packet(q, 20);
		send_buffer(q, 16'd20);
		set_limits(13'd20, 13'h1000);
	endtask

	task automatic run_phase(input int unsigned gap, input int unsigned stall,
			input logic [12:0] mn, input logic [12:0] mx, input int unsigned count);
		int unsigned start;
		set_limits(mn, mx);
		gap_pct = gap;
		stall_pct = stall;
		start = bytes_parsed;
		while (bytes_parsed - start < count) send_random_buffer();
	endtask

	task automatic test_random_traffic();
		run_phase(0, 0, 13'd20, 13'h1000, 100);
		run_phase(74, 0, 13'($urandom_range(40, 20)), 13'($urandom_range(800, 300)), 100);
		run_phase(0, 74, 13'($urandom_range(19, 0)), 13'h1000, 100);
		run_phase(29, 29, 13'($urandom_range(30, 20)), 13'($urandom_range(90, 40)), 100);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.first_byte = 1'b0;
		in_ch.buffer_len = '0;
		out_ch.ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_header_checks();
		test_attributes();
		test_length_limits();
		test_random_traffic();
		in_ch.valid <= 1'b0;
		for (int i = 0; i < 100000 && predicted_results.size() != 0; i++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (predicted_results.size() != 0) begin
			fault_count++;
			$display("%0t results missing: expected %0d more actual 0", $time,
				predicted_results.size());
		end
		$display("Sent %0d bytes (%0d parsed) under four flow-control mixes and many limit pairs.",
			bytes_taken, bytes_parsed);
		$display("Checked %0d results: %0d closures, %0d numeric values, %0d data bytes.",
			results_seen, closures_seen, values_seen, data_seen);
		if (fault_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
